// ===== hdl/i2cbe_pkg.sv =====
// Shared types and constants of the I2C master bit engine.
package i2cbe_pkg;

	// Command codes carried in the op field.
	typedef logic [2:0] op_t;
	localparam op_t OP_TICK     = 3'd0;
	localparam op_t OP_START    = 3'd1;
	localparam op_t OP_STOP     = 3'd2;
	localparam op_t OP_WRITE    = 3'd3;
	localparam op_t OP_READ     = 3'd4;
	localparam op_t OP_SEND_ACK = 3'd5;
	localparam op_t OP_RECV_ACK = 3'd6;

	localparam int unsigned TICK_W  = 10;
	localparam int unsigned PHASE_W = 5;
	localparam int unsigned BYTE_W  = 8;

	localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 10'd10;
	localparam logic [BYTE_W-1:0] TOP_BIT           = 8'h80;

	// APB register map.
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_PHASE_TICKS = 1'b0;

	// What one pin phase does.
	typedef enum logic [1:0] {
		ACT_SDA,
		ACT_SCL,
		ACT_SAMPLE
	} act_kind_t;

	// Decoded phase, handed from the phase decoder to the engine.
	typedef struct packed {
		act_kind_t  kind;
		logic       level;
		logic [2:0] bit_idx;
		logic       last;
	} phase_act_t;

endpackage

// ===== hdl/i2cbe_if.sv =====
// Valid/ready channel interfaces for the tick requests and the per-tick results.
interface i2cbe_in_if;
	import i2cbe_pkg::*;
	logic       valid;
	logic       ready;
	op_t        op;
	logic [7:0] tx_byte;
	logic       ack_level;
	logic       sda_line;

	modport source (output valid, op, tx_byte, ack_level, sda_line, input ready);
	modport sink (input valid, op, tx_byte, ack_level, sda_line, output ready);
endinterface

interface i2cbe_out_if;
	logic       valid;
	logic       ready;
	logic       scl_drive;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;
	logic       rejected;

	modport source (output valid, scl_drive, sda_drive, busy_res, done_res, rx_byte,
		ack_seen, rejected, input ready);
	modport sink (input valid, scl_drive, sda_drive, busy_res, done_res, rx_byte,
		ack_seen, rejected, output ready);
endinterface

// ===== hdl/i2cbe_cfg.sv =====
// APB register block holding the phase length setting.
module i2cbe_cfg
	import i2cbe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output logic [TICK_W-1:0]   phase_ticks
);

	logic [TICK_W-1:0] phase_ticks_q;
	logic              wr_en;

	// Registers are written in the access cycle of a write.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PHASE_TICKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RESET;
		end else if (wr_en) begin
			phase_ticks_q <= pwdata[TICK_W-1:0];
		end
	end

	// Read back the setting; unmapped addresses read as zero.
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PHASE_TICKS) begin
			prdata = {{(32-TICK_W){1'b0}}, phase_ticks_q};
		end
	end

	assign phase_ticks = phase_ticks_q;

endmodule

// ===== hdl/i2cbe_phase.sv =====
// Decodes a command and phase index into the pin action of that phase.
module i2cbe_phase
	import i2cbe_pkg::*;
(
	input  op_t                 cmd,
	input  logic [PHASE_W-1:0]  phase,
	input  logic [BYTE_W-1:0]   shift,
	output phase_act_t          act
);

	// Quotient by three for a five-bit index, by comparison.
	function automatic logic [4:0] div3(input logic [4:0] v);
		logic [4:0] q;
		q = 5'd0;
		for (int k = 1; k <= 10; k++) begin
			if (v >= 5'(3 * k)) begin
				q = 5'(k);
			end
		end
		return q;
	endfunction

	logic [4:0] q_w, qd_w, rm_w;
	logic [4:0] q_r, qd_r, rm_r;
	logic [4:0] count;

	always_comb begin
		// Write byte uses the phase index directly, read byte skips its first phase.
		q_w  = phase;
		qd_w = div3(q_w);
		rm_w = q_w - 5'(qd_w * 5'd3);
		q_r  = phase - 5'd1;
		qd_r = div3(q_r);
		rm_r = q_r - 5'(qd_r * 5'd3);

		act.kind    = ACT_SDA;
		act.level   = 1'b1;
		act.bit_idx = 3'd0;
		count       = 5'd0;

		case (cmd)
			OP_START: begin
				act.kind  = phase[0] ? ACT_SCL : ACT_SDA;
				act.level = (phase < 5'd2);
				count     = 5'd4;
			end
			OP_STOP: begin
				act.kind  = (phase == 5'd1) ? ACT_SCL : ACT_SDA;
				act.level = (phase != 5'd0);
				count     = 5'd3;
			end
			OP_WRITE: begin
				act.bit_idx = qd_w[2:0];
				if (rm_w == 5'd0) begin
					act.kind  = ACT_SDA;
					act.level = shift[3'd7 - qd_w[2:0]];
				end else begin
					act.kind  = ACT_SCL;
					act.level = (rm_w == 5'd1);
				end
				count = 5'(3 * BYTE_W);
			end
			OP_READ: begin
				if (phase != 5'd0) begin
					act.bit_idx = qd_r[2:0];
					if (rm_r == 5'd1) begin
						act.kind = ACT_SAMPLE;
					end else begin
						act.kind  = ACT_SCL;
						act.level = (rm_r == 5'd0);
					end
				end
				count = 5'(3 * BYTE_W + 1);
			end
			OP_SEND_ACK: begin
				act.kind  = (phase == 5'd0) ? ACT_SDA : ACT_SCL;
				act.level = (phase == 5'd0) ? shift[0] : (phase == 5'd1);
				count     = 5'd3;
			end
			OP_RECV_ACK: begin
				if (phase == 5'd2) begin
					act.kind = ACT_SAMPLE;
				end else begin
					act.kind  = (phase == 5'd0) ? ACT_SDA : ACT_SCL;
					act.level = (phase != 5'd3);
				end
				count = 5'd4;
			end
			default: begin
				count = 5'd0;
			end
		endcase

		// Last phase once the next index reaches the command's phase count.
		act.last = ((phase + 5'd1) >= count);
	end

endmodule

// ===== hdl/i2c_master_bit_engine.sv =====
// Top level of the tick-driven I2C master bit engine.
//
//  channel  | dir | handshake        | contents
//  ---------+-----+------------------+-------------------------------------------
//  in_ch    | in  | valid/ready      | op, tx_byte, ack_level, sda_line (one tick)
//  out_ch   | out | valid/ready      | scl/sda drive, busy, done, rx_byte, ack, rej
//  apb      | in  | psel/penable     | phase_ticks at byte address 0
//
// Every request is one tick and yields one result, computed combinationally from the
// engine state and registered in the result register; a request per cycle is taken
// while in_ch.ready is high, low only while the result register is full and not taken.
// Reset puts the engine idle with both lines released and phase_ticks at 10.
module i2c_master_bit_engine
	import i2cbe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	i2cbe_in_if.sink          in_ch,
	i2cbe_out_if.source       out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [TICK_W-1:0] phase_ticks;

	// Engine state.
	op_t                cmd_q;
	logic [PHASE_W-1:0] phase_q;
	logic [TICK_W-1:0]  tick_q;
	logic [BYTE_W-1:0]  shift_q;
	logic               scl_q, sda_q, ack_q;
	logic [BYTE_W-1:0]  rx_q;

	// Result register.
	logic               out_valid_q;
	logic               scl_out_q, sda_out_q, busy_out_q, done_out_q, ack_out_q, rej_out_q;
	logic [BYTE_W-1:0]  rx_out_q;

	// Next-state values.
	op_t                cmd_a, cmd_n;
	logic [PHASE_W-1:0] phase_a, phase_n, phase_inc;
	logic [TICK_W-1:0]  tick_a, tick_n, tick_inc, limit;
	logic [BYTE_W-1:0]  shift_a, shift_n, rx_n;
	logic               scl_n, sda_n, ack_n;
	logic               fire, valid_op, idle, start_cmd, active, done, rej, wrap;
	phase_act_t         act;

	i2cbe_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.phase_ticks (phase_ticks)
	);

	i2cbe_phase u_phase (
		.cmd   (cmd_a),
		.phase (phase_a),
		.shift (shift_a),
		.act   (act)
	);

	// A request is taken whenever the result register is free or draining.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign fire        = in_ch.valid && in_ch.ready;

	// Command launch: an idle engine loads a new command with its operand.
	always_comb begin
		valid_op  = (in_ch.op >= OP_START) && (in_ch.op <= OP_RECV_ACK);
		idle      = (cmd_q == OP_TICK);
		start_cmd = idle && valid_op;
		rej       = !idle && valid_op;
		cmd_a     = start_cmd ? in_ch.op : cmd_q;
		phase_a   = start_cmd ? '0 : phase_q;
		tick_a    = start_cmd ? '0 : tick_q;
		shift_a   = shift_q;
		if (start_cmd) begin
			case (in_ch.op)
				OP_WRITE:    shift_a = in_ch.tx_byte;
				OP_READ:     shift_a = '0;
				OP_SEND_ACK: shift_a = {{(BYTE_W-1){1'b0}}, in_ch.ack_level};
				default:     shift_a = shift_q;
			endcase
		end
	end

	// Phase action on the first tick of a phase, then tick and phase counting.
	always_comb begin
		active    = (cmd_a != OP_TICK);
		cmd_n     = cmd_a;
		phase_n   = phase_a;
		tick_n    = tick_a;
		shift_n   = shift_a;
		scl_n     = scl_q;
		sda_n     = sda_q;
		ack_n     = ack_q;
		rx_n      = rx_q;
		done      = 1'b0;
		limit     = (phase_ticks == '0) ? TICK_W'(1) : phase_ticks;
		tick_inc  = tick_a + TICK_W'(1);
		phase_inc = phase_a + PHASE_W'(1);
		wrap      = (tick_inc >= limit) || (tick_inc == '0);

		if (active) begin
			if (tick_a == '0) begin
				case (act.kind)
					ACT_SDA: sda_n = act.level;
					ACT_SCL: scl_n = act.level;
					ACT_SAMPLE: begin
						if (cmd_a == OP_READ) begin
							if (in_ch.sda_line) begin
								shift_n = shift_a | (TOP_BIT >> act.bit_idx);
							end
						end else begin
							ack_n = in_ch.sda_line;
						end
					end
					default: ;
				endcase
			end
			tick_n = tick_inc;
			if (wrap) begin
				tick_n  = '0;
				phase_n = phase_inc;
				if (act.last) begin
					if (cmd_a == OP_READ) begin
						rx_n = shift_n;
					end
					cmd_n   = OP_TICK;
					phase_n = '0;
					done    = 1'b1;
				end
			end
		end
	end

	// Engine state advances on every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= OP_TICK;
			phase_q <= '0;
			tick_q  <= '0;
			shift_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b1;
			rx_q    <= '0;
		end else if (fire) begin
			cmd_q   <= cmd_n;
			phase_q <= phase_n;
			tick_q  <= tick_n;
			shift_q <= shift_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			ack_q   <= ack_n;
			rx_q    <= rx_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			scl_out_q  <= scl_n;
			sda_out_q  <= sda_n;
			busy_out_q <= (cmd_n != OP_TICK);
			done_out_q <= done;
			rx_out_q   <= rx_n;
			ack_out_q  <= ack_n;
			rej_out_q  <= rej;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.scl_drive = scl_out_q;
	assign out_ch.sda_drive = sda_out_q;
	assign out_ch.busy_res  = busy_out_q;
	assign out_ch.done_res  = done_out_q;
	assign out_ch.rx_byte   = rx_out_q;
	assign out_ch.ack_seen  = ack_out_q;
	assign out_ch.rejected  = rej_out_q;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the I2C master bit engine: a directed table, then random bus traffic.
module tb_top
	import i2cbe_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// An op code outside the defined set, carrying no command.
	localparam op_t OP_NONE = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_ITEMS_PER_SETTING = 55;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rx;
		logic       ack;
		logic       rej;
	} tick_result_t;

	// One row of the directed table: a register write when cfg is not negative,
	// else a request repeated reps times.
	typedef struct {
		int         cfg;
		op_t        op;
		logic [7:0] tx;
		logic       ack;
		logic       sda;
		int         reps;
		bit         typed;
	} stim_row_t;

	typedef enum {
		SEQ_START, SEQ_ADDR, SEQ_ADDR_ACK, SEQ_DATA, SEQ_WR_ACK, SEQ_RD_ACK, SEQ_STOP
	} bus_step_t;

	// Lines released, nothing running: what an idle engine reports after reset.
	localparam tick_result_t IDLE_RESULT = '{scl: 1'b1, sda: 1'b1, busy: 1'b0, done: 1'b0,
		rx: 8'h00, ack: 1'b1, rej: 1'b0};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	i2cbe_in_if  in_ch();
	i2cbe_out_if out_ch();

	i2c_master_bit_engine uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the engine; idle is coded as the tick-only op.
	op_t               eng_cmd;
	logic [PHASE_W-1:0] eng_phase;
	logic [TICK_W-1:0] eng_ticks;
	logic [TICK_W-1:0] ticks_setting;
	logic [7:0]        eng_shift;
	logic [7:0]        eng_rx;
	logic              eng_scl;
	logic              eng_sda;
	logic              eng_ack;

	// Set by the driver together with a request whose answer is typed into the table.
	bit                req_typed;

	tick_result_t expected_ticks[$];
	stim_row_t    directed_rows[$];

	int  errors;
	int  reports;
	int  checked;
	int  cmds_done;
	int  cmds_rejected;
	int  settings_used;
	int  cycles;
	bit  calm;

	// Advances the shadow engine by one tick and returns what the block must report.
	function automatic tick_result_t engine_tick(op_t op, logic [7:0] tx, logic ack_lvl,
		logic sda_in);
		tick_result_t      r;
		act_kind_t         kind;
		logic              level;
		bit                acts;
		bit                cmd_op;
		int                p;
		int                q;
		int                bitn;
		int                total;
		logic [TICK_W-1:0] lim;
		r = '0;
		kind = ACT_SDA;
		level = 1'b1;
		acts = 1'b1;
		bitn = 0;
		q = 0;
		total = 0;
		lim = (ticks_setting == '0) ? TICK_W'(1) : ticks_setting;
		cmd_op = (op >= OP_START && op <= OP_RECV_ACK);

		// A command is taken only while idle; one that arrives while busy is refused.
		if (eng_cmd != OP_TICK) begin
			if (cmd_op)
				r.rej = 1'b1;
		end else if (cmd_op) begin
			eng_cmd = op;
			eng_phase = '0;
			eng_ticks = '0;
			if (op == OP_WRITE)
				eng_shift = tx;
			else if (op == OP_READ)
				eng_shift = '0;
			else if (op == OP_SEND_ACK)
				eng_shift = {7'd0, ack_lvl};
		end

		if (eng_cmd != OP_TICK) begin
			p = int'(eng_phase);
			case (eng_cmd)
				OP_START: total = 4;
				OP_STOP: total = 3;
				OP_WRITE: total = 24;
				OP_READ: total = 25;
				OP_SEND_ACK: total = 3;
				OP_RECV_ACK: total = 4;
				default: total = 0;
			endcase

			// A phase acts on its first tick only.
			if (eng_ticks == '0) begin
				case (eng_cmd)
					OP_START: begin
						kind = p[0] ? ACT_SCL : ACT_SDA;
						level = (p < 2);
					end
					OP_STOP: begin
						kind = (p == 1) ? ACT_SCL : ACT_SDA;
						level = (p != 0);
					end
					OP_WRITE: begin
						bitn = (p / 3) % 8;
						if (p % 3 == 0) begin
							kind = ACT_SDA;
							level = eng_shift[7 - bitn];
						end else begin
							kind = ACT_SCL;
							level = (p % 3 == 1);
						end
					end
					OP_READ: begin
						if (p == 0) begin
							kind = ACT_SDA;
							level = 1'b1;
						end else begin
							q = p - 1;
							bitn = (q / 3) % 8;
							if (q % 3 == 1) begin
								kind = ACT_SAMPLE;
							end else begin
								kind = ACT_SCL;
								level = (q % 3 == 0);
							end
						end
					end
					OP_SEND_ACK: begin
						kind = (p == 0) ? ACT_SDA : ACT_SCL;
						level = (p == 0) ? eng_shift[0] : (p == 1);
					end
					OP_RECV_ACK: begin
						if (p == 2) begin
							kind = ACT_SAMPLE;
						end else begin
							kind = (p == 0) ? ACT_SDA : ACT_SCL;
							level = (p != 3);
						end
					end
					default: acts = 1'b0;
				endcase

				if (acts) begin
					if (kind == ACT_SDA) begin
						eng_sda = level;
					end else if (kind == ACT_SCL) begin
						eng_scl = level;
					end else if (eng_cmd == OP_READ) begin
						if (sda_in)
							eng_shift = eng_shift | (TOP_BIT >> bitn);
					end else begin
						eng_ack = sda_in;
					end
				end
			end

			// The phase ends once its count reaches or passes the current setting.
			eng_ticks = eng_ticks + 1'b1;
			if (eng_ticks >= lim || eng_ticks == '0) begin
				eng_ticks = '0;
				eng_phase = eng_phase + 1'b1;
				if (int'(eng_phase) >= total) begin
					if (eng_cmd == OP_READ)
						eng_rx = eng_shift;
					eng_cmd = OP_TICK;
					eng_phase = '0;
					r.done = 1'b1;
				end
			end
		end

		r.scl = eng_scl;
		r.sda = eng_sda;
		r.busy = (eng_cmd != OP_TICK);
		r.rx = eng_rx;
		r.ack = eng_ack;
		return r;
	endfunction

	task automatic add_row(int cfg, op_t op, logic [7:0] tx, logic ack, logic sda, int reps,
		bit typed);
		directed_rows.push_back('{cfg: cfg, op: op, tx: tx, ack: ack, sda: sda, reps: reps,
			typed: typed});
	endtask

	// Offers one request after a random gap and returns at the falling edge after it is taken.
	task automatic send_req(op_t op, logic [7:0] tx, logic ack_lvl, logic sda, bit typed);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.op <= op;
		in_ch.tx_byte <= tx;
		in_ch.ack_level <= ack_lvl;
		in_ch.sda_line <= sda;
		req_typed <= typed;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		@(negedge clk);
	endtask

	// One APB transfer: setup cycle, access cycle, then a cycle with the bus idle.
	task automatic reg_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'(4 * REG_PHASE_TICKS);
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Lets every outstanding result drain, then writes phase_ticks and reads it back.
	task automatic set_phase_ticks(logic [TICK_W-1:0] val);
		logic [31:0] rd;
		in_ch.valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		reg_access(1'b1, 32'(val), rd);
		ticks_setting = val;
		reg_access(1'b0, 32'd0, rd);
		if (rd[TICK_W-1:0] !== val) begin
			errors++;
			if (reports < MAX_REPORTS) begin
				reports++;
				$display("phase_ticks readback: expected %0d, got %0d", val, rd[TICK_W-1:0]);
			end
		end
		settings_used++;
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results still due.", cycles,
				expected_ticks.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Predict on each accepted request, check each accepted result against the oldest one due.
	always @(posedge clk) begin
		tick_result_t want;
		tick_result_t got;
		bit           bad;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				want = engine_tick(in_ch.op, in_ch.tx_byte, in_ch.ack_level, in_ch.sda_line);
				cmds_done += int'(want.done);
				cmds_rejected += int'(want.rej);
				expected_ticks.push_back(req_typed ? IDLE_RESULT : want);
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{scl: out_ch.scl_drive, sda: out_ch.sda_drive, busy: out_ch.busy_res,
					done: out_ch.done_res, rx: out_ch.rx_byte, ack: out_ch.ack_seen,
					rej: out_ch.rejected};
				if (expected_ticks.size() == 0) begin
					errors++;
					if (reports < MAX_REPORTS) begin
						reports++;
						$display("result with nothing due: %p", got);
					end
				end else begin
					want = expected_ticks.pop_front();
					checked++;
					bad = (got.scl !== want.scl) || (got.sda !== want.sda) ||
						(got.busy !== want.busy) || (got.done !== want.done) ||
						(got.rx !== want.rx) || (got.ack !== want.ack) || (got.rej !== want.rej);
					if (bad) begin
						errors++;
						if (reports < MAX_REPORTS) begin
							reports++;
							$display("result %0d: expected scl=%b sda=%b busy=%b done=%b rx=%h ack=%b rej=%b",
								checked, want.scl, want.sda, want.busy, want.done, want.rx,
								want.ack, want.rej);
							$display("result %0d:      got scl=%b sda=%b busy=%b done=%b rx=%h ack=%b rej=%b",
								checked, got.scl, got.sda, got.busy, got.done, got.rx,
								got.ack, got.rej);
						end
					end
				end
			end
		end
	end

	// Result side: a random stall before each result is taken.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	// Stimulus.
	initial begin
		int          ticks_plan[8];
		int          n;
		int          roll;
		op_t         op;
		logic [7:0]  tx;
		logic        ackl;
		logic        sda;
		bus_step_t   step;

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_TICK;
		in_ch.tx_byte = 8'h00;
		in_ch.ack_level = 1'b0;
		in_ch.sda_line = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'd0;
		req_typed = 1'b0;
		calm = 1'b0;
		errors = 0;
		reports = 0;
		checked = 0;
		cmds_done = 0;
		cmds_rejected = 0;
		settings_used = 0;
		cycles = 0;
		step = SEQ_START;

		eng_cmd = OP_TICK;
		eng_phase = '0;
		eng_ticks = '0;
		ticks_setting = PHASE_TICKS_RESET;
		eng_shift = 8'h00;
		eng_rx = 8'h00;
		eng_scl = 1'b1;
		eng_sda = 1'b1;
		eng_ack = 1'b1;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: reset state, every command, byte extremes, a refused command,
		// the zero setting, the longest setting and a setting change in mid phase.
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b0, 1, 1'b1);
		add_row(-1, OP_NONE, 8'hFF, 1'b1, 1'b1, 1, 1'b1);
		add_row(1, OP_TICK, 8'h00, 1'b0, 1'b0, 0, 1'b0);
		add_row(-1, OP_START, 8'h00, 1'b0, 1'b1, 1, 1'b0);
		add_row(-1, OP_STOP, 8'h00, 1'b0, 1'b1, 1, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b1, 2, 1'b0);
		add_row(-1, OP_WRITE, 8'hFF, 1'b0, 1'b1, 1, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b1, 23, 1'b0);
		add_row(-1, OP_RECV_ACK, 8'h00, 1'b0, 1'b0, 1, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b0, 3, 1'b0);
		add_row(-1, OP_READ, 8'h00, 1'b0, 1'b1, 1, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b1, 24, 1'b0);
		add_row(-1, OP_READ, 8'hFF, 1'b1, 1'b0, 1, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b0, 24, 1'b0);
		add_row(-1, OP_WRITE, 8'h00, 1'b0, 1'b0, 1, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b0, 23, 1'b0);
		add_row(-1, OP_SEND_ACK, 8'h00, 1'b1, 1'b0, 1, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b0, 2, 1'b0);
		add_row(-1, OP_SEND_ACK, 8'hFF, 1'b0, 1'b1, 1, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b1, 2, 1'b0);
		add_row(-1, OP_RECV_ACK, 8'h00, 1'b0, 1'b1, 1, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b1, 3, 1'b0);
		add_row(0, OP_TICK, 8'h00, 1'b0, 1'b0, 0, 1'b0);
		add_row(-1, OP_STOP, 8'h00, 1'b0, 1'b0, 1, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b0, 2, 1'b0);
		add_row(1023, OP_TICK, 8'h00, 1'b0, 1'b0, 0, 1'b0);
		add_row(-1, OP_START, 8'h00, 1'b0, 1'b1, 1, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b1, 40, 1'b0);
		add_row(3, OP_TICK, 8'h00, 1'b0, 1'b0, 0, 1'b0);
		add_row(-1, OP_TICK, 8'h00, 1'b0, 1'b1, 12, 1'b0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].cfg >= 0) begin
				set_phase_ticks(TICK_W'(directed_rows[i].cfg));
			end else begin
				repeat (directed_rows[i].reps)
					send_req(directed_rows[i].op, directed_rows[i].tx, directed_rows[i].ack,
						directed_rows[i].sda, directed_rows[i].typed);
			end
		end

		// Random part: mostly well-formed bus transactions with random data,
		// some noise, and refused commands while the engine is busy.
		ticks_plan = '{1, 2, 1, 3, 0, 1, 4, 1};
		foreach (ticks_plan[s]) begin
			set_phase_ticks(TICK_W'(ticks_plan[s]));
			calm = (s == 2 || s == 5);
			n = 0;
			while (n < RAND_ITEMS_PER_SETTING) begin
				tx = 8'($urandom);
				ackl = 1'($urandom);
				sda = 1'($urandom);
				roll = $urandom_range(0, 99);
				if (eng_cmd != OP_TICK) begin
					if (roll < 88)
						op = OP_TICK;
					else if (roll < 96)
						op = op_t'($urandom_range(1, 6));
					else
						op = OP_NONE;
				end else if (roll < 85) begin
					case (step)
						SEQ_START: begin
							op = OP_START;
							step = SEQ_ADDR;
						end
						SEQ_ADDR: begin
							op = OP_WRITE;
							step = SEQ_ADDR_ACK;
						end
						SEQ_ADDR_ACK: begin
							op = OP_RECV_ACK;
							step = SEQ_DATA;
						end
						SEQ_DATA: begin
							if ($urandom_range(0, 1) != 0) begin
								op = OP_WRITE;
								step = SEQ_WR_ACK;
							end else begin
								op = OP_READ;
								step = SEQ_RD_ACK;
							end
						end
						SEQ_WR_ACK: begin
							op = OP_RECV_ACK;
							step = ($urandom_range(0, 2) == 0) ? SEQ_STOP : SEQ_DATA;
						end
						SEQ_RD_ACK: begin
							op = OP_SEND_ACK;
							step = ($urandom_range(0, 2) == 0) ? SEQ_STOP : SEQ_DATA;
						end
						default: begin
							op = OP_STOP;
							step = SEQ_START;
						end
					endcase
				end else begin
					op = op_t'($urandom_range(0, 7));
				end
				send_req(op, tx, ackl, sda, 1'b0);
				if (op != OP_NONE)
					n++;
			end
		end

		// Drain, then keep the bench running so that any stray result from the result register shows.
		in_ch.valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		$display("Checked %0d tick results over %0d phase_ticks settings, 0, 1 and 1023 included.",
			checked, settings_used);
		$display("Engine finished %0d commands and refused %0d while busy; %0d errors.",
			cmds_done, cmds_rejected, errors);
		if (errors == 0 && expected_ticks.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
